@@ src/pee_pkg.sv @@
// pee_pkg: shared types and constants of the postfix expression evaluator
// holds character codes, error codes, controller states and the command/status structs
// no dependencies
package pee_pkg;

  localparam int OUT_WIDTH = 32;
  localparam int ERR_WIDTH = 2;
  localparam int SYM_WIDTH = 8;

  localparam logic [SYM_WIDTH-1:0] CH_NUL   = 8'h00;
  localparam logic [SYM_WIDTH-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_WIDTH-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_WIDTH-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_WIDTH-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_WIDTH-1:0] CH_SLASH = 8'h2F;
  localparam logic [SYM_WIDTH-1:0] CH_PCT   = 8'h25;

  typedef enum logic [ERR_WIDTH-1:0] {
    ERR_OK    = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIV0  = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MOD
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_B,
    ST_READ_A,
    ST_EXEC,
    ST_BUSY,
    ST_TERM
  } state_t;

  typedef enum logic {
    WR_DIGIT,
    WR_ALU
  } wr_sel_t;

  typedef struct packed {
    logic    rd_en;
    logic    load_b;
    logic    load_a;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    start_unit;
    op_t     op;
    logic    load_out;
    logic    out_empty;
    err_t    out_error;
  } cmd_t;

  typedef struct packed {
    logic b_zero;
    logic unit_done;
    logic out_free;
  } sts_t;

endpackage

@@ src/pee_sym_if.sv @@
// pee_sym_if: input channel carrying one expression character per transaction
// depends on pee_pkg for the symbol width
interface pee_sym_if
  import pee_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [SYM_WIDTH-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink (input valid, input symbol, output ready);
endinterface

@@ src/pee_res_if.sv @@
// pee_res_if: output channel carrying the result value and error code per transaction
// depends on pee_pkg for the field widths
interface pee_res_if
  import pee_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] value;
  logic [ERR_WIDTH-1:0]        error_code;

  modport source (output valid, output value, output error_code, input ready);
  modport sink (input valid, input value, input error_code, output ready);
endinterface

@@ src/postfix_expression_evaluator_core.sv @@
// postfix_expression_evaluator_core: top level, joins controller and datapath to the channels
// depends on pee_pkg, pee_sym_if, pee_res_if, pee_ctrl and pee_datapath
//
// Evaluates a postfix expression fed one character per transaction on symbols. Operator
// characters + - * / % pop two values and push the result, a zero byte delivers the top of
// stack with the sticky error code on results and empties the stack, and every other byte
// pushes its code minus 48. After an operand the next character is accepted in the following
// cycle. An add or subtract reads the stack ram twice, then writes the result. Multiply,
// divide and remainder run on one shared bit-serial unit; a divide or remainder by zero stops
// without starting the unit, and an operator that underflows or an operand that overflows is
// only flagged. A terminator waits until the previous result has left the output register.
// Underflow, overflow and divide by zero leave the stack unchanged; the first one in an
// expression is reported with its result.
module postfix_expression_evaluator_core
  import pee_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  pee_sym_if.sink   symbols,
  pee_res_if.source results
);

  cmd_t                           cmd;
  sts_t                           sts;
  logic [$clog2(STACK_DEPTH)-1:0] rd_addr;
  logic [$clog2(STACK_DEPTH)-1:0] wr_addr;
  logic                           res_valid;
  logic signed [OUT_WIDTH-1:0]    res_value;
  logic [ERR_WIDTH-1:0]           res_error;
  logic                           sym_ready;

  pee_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sym_valid(symbols.valid),
    .symbol   (symbols.symbol),
    .sym_ready(sym_ready),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr)
  );

  pee_datapath #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .symbol    (symbols.symbol),
    .sts       (sts),
    .res_ready (results.ready),
    .res_valid (res_valid),
    .value     (res_value),
    .error_code(res_error)
  );

  assign symbols.ready      = sym_ready;
  assign results.valid      = res_valid;
  assign results.value      = res_value;
  assign results.error_code = res_error;

endmodule

@@ src/pee_ram.sv @@
// pee_ram: generic single write port, single read port ram with registered read data
// no dependencies
module pee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/pee_muldiv.sv @@
// pee_muldiv: shared iterative unit, shift-add multiply and restoring signed divide/remainder
// one bit per cycle; depends on pee_pkg for op_t
module pee_muldiv
  import pee_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  op_t              op,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  localparam int CW = $clog2(WIDTH);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] sh_a;
  logic [WIDTH-1:0] sh_b;
  logic             neg_q;
  logic             neg_r;
  op_t              mode;
  logic [WIDTH+1:0] diff;
  logic [WIDTH-1:0] mag_a;
  logic [WIDTH-1:0] mag_b;

  assign mag_a = a[WIDTH-1] ? (WIDTH'(0) - a) : a;
  assign mag_b = b[WIDTH-1] ? (WIDTH'(0) - b) : b;
  assign diff  = {1'b0, acc, sh_a[WIDTH-1]} - {2'b00, sh_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= CW'(WIDTH - 1);
      acc   <= '0;
      mode  <= op;
      neg_q <= a[WIDTH-1] ^ b[WIDTH-1];
      neg_r <= a[WIDTH-1];
      if (op == OP_MUL) begin
        sh_a <= a;
        sh_b <= b;
      end else begin
        sh_a <= mag_a;
        sh_b <= mag_b;
      end
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (mode == OP_MUL) begin
        if (sh_b[0]) begin
          acc <= acc + sh_a;
        end
        sh_a <= {sh_a[WIDTH-2:0], 1'b0};
        sh_b <= {1'b0, sh_b[WIDTH-1:1]};
      end else begin
        if (!diff[WIDTH+1]) begin
          acc <= diff[WIDTH-1:0];
        end else begin
          acc <= {acc[WIDTH-2:0], sh_a[WIDTH-1]};
        end
        sh_a <= {sh_a[WIDTH-2:0], ~diff[WIDTH+1]};
      end
    end
  end

  always_comb begin
    case (mode)
      OP_MUL:  result = acc;
      OP_DIV:  result = neg_q ? (WIDTH'(0) - sh_a) : sh_a;
      OP_MOD:  result = neg_r ? (WIDTH'(0) - acc) : acc;
      default: result = acc;
    endcase
  end

endmodule

@@ src/pee_datapath.sv @@
// pee_datapath: operand stack ram, operand registers, add/sub, iterative unit, result register
// depends on pee_pkg, pee_ram and pee_muldiv
module pee_datapath
  import pee_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cmd_t                           cmd,
  input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
  input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
  input  logic [SYM_WIDTH-1:0]           symbol,
  output sts_t                           sts,
  input  logic                           res_ready,
  output logic                           res_valid,
  output logic signed [OUT_WIDTH-1:0]    value,
  output logic [ERR_WIDTH-1:0]           error_code
);

  logic [VALUE_WIDTH-1:0] rd_data;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [VALUE_WIDTH-1:0] opnd_a;
  logic [VALUE_WIDTH-1:0] opnd_b;
  logic [VALUE_WIDTH-1:0] alu_res;
  logic [VALUE_WIDTH-1:0] unit_res;
  logic [VALUE_WIDTH-1:0] digit;
  logic                   unit_done;

  pee_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  pee_muldiv #(
    .WIDTH(VALUE_WIDTH)
  ) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_unit),
    .op    (cmd.op),
    .a     (opnd_a),
    .b     (opnd_b),
    .done  (unit_done),
    .result(unit_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_b) begin
      opnd_b <= rd_data;
    end
    if (cmd.load_a) begin
      opnd_a <= rd_data;
    end
  end

  assign digit = VALUE_WIDTH'(symbol) - VALUE_WIDTH'(CH_ZERO);

  always_comb begin
    case (cmd.op)
      OP_ADD:  alu_res = opnd_a + opnd_b;
      OP_SUB:  alu_res = opnd_a - opnd_b;
      default: alu_res = unit_res;
    endcase
  end

  assign wr_data = (cmd.wr_sel == WR_DIGIT) ? digit : alu_res;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      value      <= cmd.out_empty ? '0 : OUT_WIDTH'($signed(rd_data));
      error_code <= cmd.out_error;
    end
  end

  assign sts.b_zero    = (opnd_b == '0);
  assign sts.unit_done = unit_done;
  assign sts.out_free  = !res_valid || res_ready;

endmodule

@@ src/pee_ctrl.sv @@
// pee_ctrl: controller state machine, stack depth counter and sticky error
// depends on pee_pkg
module pee_ctrl
  import pee_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sym_valid,
  input  logic [SYM_WIDTH-1:0]           symbol,
  output logic                           sym_ready,
  input  sts_t                           sts,
  output cmd_t                           cmd,
  output logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
  output logic [$clog2(STACK_DEPTH)-1:0] wr_addr
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  state_t        state;
  state_t        state_next;
  op_t           op;
  op_t           op_next;
  logic [DW-1:0] depth;
  logic [DW-1:0] depth_next;
  err_t          err;
  err_t          err_next;

  logic          accept;
  logic          is_term;
  logic          is_op;
  op_t           sym_op;
  logic          is_divide;
  logic [DW-1:0] top_idx;
  logic [DW-1:0] sec_idx;

  assign sym_ready = (state == ST_IDLE);
  assign accept    = sym_valid && sym_ready;
  assign is_term   = (symbol == CH_NUL);
  assign is_op     = symbol inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT};
  assign is_divide = (op == OP_DIV) || (op == OP_MOD);
  assign top_idx   = depth - DW'(1);
  assign sec_idx   = depth - DW'(2);

  always_comb begin
    case (symbol)
      CH_PLUS:  sym_op = OP_ADD;
      CH_MINUS: sym_op = OP_SUB;
      CH_STAR:  sym_op = OP_MUL;
      CH_SLASH: sym_op = OP_DIV;
      CH_PCT:   sym_op = OP_MOD;
      default:  sym_op = OP_ADD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_ADD;
      depth <= '0;
      err   <= ERR_OK;
    end else begin
      state <= state_next;
      op    <= op_next;
      depth <= depth_next;
      err   <= err_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_term) begin
            state_next = ST_TERM;
          end else if (is_op && depth >= DW'(2)) begin
            state_next = ST_READ_B;
          end
        end
      end
      ST_READ_B: state_next = ST_READ_A;
      ST_READ_A: state_next = ST_EXEC;
      ST_EXEC: begin
        if (is_divide && sts.b_zero) begin
          state_next = ST_IDLE;
        end else if (op == OP_ADD || op == OP_SUB) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (sts.unit_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_TERM: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands, depth and error
  always_comb begin
    cmd            = '0;
    cmd.wr_sel     = WR_ALU;
    cmd.op         = op;
    cmd.out_error  = err;
    rd_addr        = top_idx[AW-1:0];
    wr_addr        = sec_idx[AW-1:0];
    op_next        = op;
    depth_next     = depth;
    err_next       = err;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_term) begin
            if (depth == '0) begin
              err_next = (err == ERR_OK) ? ERR_UNDER : err;
            end else begin
              cmd.rd_en = 1'b1;
            end
          end else if (is_op) begin
            if (depth < DW'(2)) begin
              err_next = (err == ERR_OK) ? ERR_UNDER : err;
            end else begin
              cmd.rd_en = 1'b1;
              op_next   = sym_op;
            end
          end else if (depth == DW'(STACK_DEPTH)) begin
            err_next = (err == ERR_OK) ? ERR_OVER : err;
          end else begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_DIGIT;
            wr_addr    = depth[AW-1:0];
            depth_next = depth + DW'(1);
          end
        end
      end
      ST_READ_B: begin
        cmd.load_b = 1'b1;
        cmd.rd_en  = 1'b1;
        rd_addr    = sec_idx[AW-1:0];
      end
      ST_READ_A: begin
        cmd.load_a = 1'b1;
      end
      ST_EXEC: begin
        if (is_divide && sts.b_zero) begin
          err_next = (err == ERR_OK) ? ERR_DIV0 : err;
        end else if (op == OP_ADD || op == OP_SUB) begin
          cmd.wr_en  = 1'b1;
          depth_next = depth - DW'(1);
        end else begin
          cmd.start_unit = 1'b1;
        end
      end
      ST_BUSY: begin
        if (sts.unit_done) begin
          cmd.wr_en  = 1'b1;
          depth_next = depth - DW'(1);
        end
      end
      ST_TERM: begin
        if (sts.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.out_empty = (depth == '0);
          depth_next    = '0;
          err_next      = ERR_OK;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ src/pee_checker.sv @@
// pee_checker: port-level assertions for the postfix expression evaluator
// bound to postfix_expression_evaluator_core; depends on pee_pkg
module pee_checker
  import pee_pkg::*;
(
  input logic                        clk,
  input logic                        rst,
  input logic                        sym_valid,
  input logic                        sym_ready,
  input logic [SYM_WIDTH-1:0]        symbol,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic signed [OUT_WIDTH-1:0] value,
  input logic [ERR_WIDTH-1:0]        error_code
);

  // result holds while stalled
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(value) && $stable(error_code))
    else $error("result changed while stalled");

  // terminator transaction blocks input until its result is produced
  a_term_blocks: assert property (@(posedge clk) disable iff (rst)
    sym_valid && sym_ready && symbol == CH_NUL |=> !sym_ready)
    else $error("input accepted right after terminator");

  // a new result follows a cycle with input blocked
  a_res_after_term: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(!sym_ready))
    else $error("result without terminator handling");

  // reset leaves the block ready and empty
  a_reset_state: assert property (@(posedge clk)
    rst |=> sym_ready && !res_valid)
    else $error("bad state after reset");

endmodule

bind postfix_expression_evaluator_core pee_checker u_pee_checker (
  .clk       (clk),
  .rst       (rst),
  .sym_valid (symbols.valid),
  .sym_ready (symbols.ready),
  .symbol    (symbols.symbol),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .value     (results.value),
  .error_code(results.error_code)
);

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench for postfix_expression_evaluator_core
// a directed table, then random postfix expressions; results are checked against the table's
// values or a behavioral stack evaluator; depends on pee_pkg, pee_sym_if, pee_res_if and the core
`timescale 1ns / 100ps

module tb_top
  import pee_pkg::*;
;
  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int RANDOM_ITEMS = 1750;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] value;
    err_t                        code;
  } outcome_t;

  typedef struct packed {
    logic [SYM_WIDTH-1:0] symbol;
    bit                   typed;
    outcome_t             want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  pee_sym_if sym_ch ();
  pee_res_if res_ch ();

  postfix_expression_evaluator_core #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .symbols (sym_ch.sink),
    .results (res_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // evaluator state
  logic [VALUE_WIDTH-1:0] eval_stack [STACK_DEPTH];
  int                     eval_depth = 0;
  err_t                   eval_error = ERR_OK;

  outcome_t pending_results [$];
  int       failures = 0;
  int       sent_items = 0;
  int       send_idle_pct = 6;
  int       recv_idle_pct = 70;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CH_NUL,           1'b1, '{32'sd0,   ERR_UNDER}},
    '{8'hFF,            1'b0, '{32'sd0,   ERR_OK}},
    '{CH_NUL,           1'b1, '{32'sd207, ERR_OK}},
    '{CH_PLUS,          1'b0, '{32'sd0,   ERR_OK}},
    '{CH_NUL,           1'b1, '{32'sd0,   ERR_UNDER}},
    '{CH_ZERO + 8'd7,   1'b0, '{32'sd0,   ERR_OK}},
    '{CH_ZERO,          1'b0, '{32'sd0,   ERR_OK}},
    '{CH_SLASH,         1'b0, '{32'sd0,   ERR_OK}},
    '{CH_PCT,           1'b0, '{32'sd0,   ERR_OK}},
    '{CH_NUL,           1'b1, '{32'sd0,   ERR_DIV0}},
    '{8'h01,            1'b0, '{32'sd0,   ERR_OK}},
    '{CH_ZERO + 8'd5,   1'b0, '{32'sd0,   ERR_OK}},
    '{CH_SLASH,         1'b0, '{32'sd0,   ERR_OK}},
    '{8'h01,            1'b0, '{32'sd0,   ERR_OK}},
    '{CH_ZERO + 8'd5,   1'b0, '{32'sd0,   ERR_OK}},
    '{CH_PCT,           1'b0, '{32'sd0,   ERR_OK}},
    '{CH_PLUS,          1'b0, '{32'sd0,   ERR_OK}},
    '{CH_ZERO + 8'd9,   1'b0, '{32'sd0,   ERR_OK}},
    '{CH_STAR,          1'b0, '{32'sd0,   ERR_OK}},
    '{CH_ZERO + 8'd9,   1'b0, '{32'sd0,   ERR_OK}},
    '{CH_MINUS,         1'b0, '{32'sd0,   ERR_OK}},
    '{CH_NUL,           1'b0, '{32'sd0,   ERR_OK}},
    '{CH_ZERO + 8'd3,   1'b0, '{32'sd0,   ERR_OK}},
    '{CH_ZERO + 8'd4,   1'b0, '{32'sd0,   ERR_OK}},
    '{CH_NUL,           1'b1, '{32'sd4,   ERR_OK}}
  };

  function automatic bit is_operator(input logic [SYM_WIDTH-1:0] s);
    return s == CH_PLUS || s == CH_MINUS || s == CH_STAR || s == CH_SLASH || s == CH_PCT;
  endfunction

  function automatic void flag_error(input err_t code);
    if (eval_error == ERR_OK) begin
      eval_error = code;
    end
  endfunction

  // applies one symbol to the evaluator, returns 1 when a result is produced
  function automatic bit eval_symbol(input logic [SYM_WIDTH-1:0] s, output outcome_t res);
    logic [VALUE_WIDTH-1:0] a, b, ma, mb, q;
    res = '0;
    if (s == CH_NUL) begin
      if (eval_depth == 0) begin
        flag_error(ERR_UNDER);
      end else begin
        res.value = eval_stack[eval_depth-1];
      end
      res.code = eval_error;
      eval_depth = 0;
      eval_error = ERR_OK;
      return 1'b1;
    end
    if (is_operator(s)) begin
      if (eval_depth < 2) begin
        flag_error(ERR_UNDER);
        return 1'b0;
      end
      b = eval_stack[eval_depth-1];
      a = eval_stack[eval_depth-2];
      if ((s == CH_SLASH || s == CH_PCT) && b == '0) begin
        flag_error(ERR_DIV0);
        return 1'b0;
      end
      ma = a[VALUE_WIDTH-1] ? -a : a;
      mb = b[VALUE_WIDTH-1] ? -b : b;
      case (s)
        CH_PLUS:  q = a + b;
        CH_MINUS: q = a - b;
        CH_STAR:  q = a * b;
        CH_SLASH: begin
          q = ma / mb;
          if (a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1]) q = -q;
        end
        default: begin
          q = ma % mb;
          if (a[VALUE_WIDTH-1]) q = -q;
        end
      endcase
      eval_stack[eval_depth-2] = q;
      eval_depth--;
      return 1'b0;
    end
    if (eval_depth >= STACK_DEPTH) begin
      flag_error(ERR_OVER);
      return 1'b0;
    end
    eval_stack[eval_depth] = VALUE_WIDTH'(s) - VALUE_WIDTH'(CH_ZERO);
    eval_depth++;
    return 1'b0;
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_symbol(input logic [SYM_WIDTH-1:0] s, input bit typed = 1'b0,
                             input outcome_t fixed_want = '0);
    outcome_t predicted;
    if (sent_items < RANDOM_ITEMS / 3) begin
      send_idle_pct = 6;
      recv_idle_pct = 70;
    end else if (sent_items < 2 * RANDOM_ITEMS / 3) begin
      send_idle_pct = 70;
      recv_idle_pct = 6;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      sym_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sym_ch.valid <= 1'b1;
    sym_ch.symbol <= s;
    do @(posedge clk); while (sym_ch.ready !== 1'b1);
    if (eval_symbol(s, predicted)) begin
      pending_results.push_back(typed ? fixed_want : predicted);
    end
    sent_items++;
    @(negedge clk);
  endtask

  function automatic logic [SYM_WIDTH-1:0] rand_operand();
    logic [SYM_WIDTH-1:0] s;
    if ($urandom_range(99) < 40) begin
      return CH_ZERO + SYM_WIDTH'($urandom_range(9));
    end
    do s = SYM_WIDTH'($urandom_range(255)); while (s == CH_NUL || is_operator(s));
    return s;
  endfunction

  function automatic logic [SYM_WIDTH-1:0] rand_operator();
    case ($urandom_range(4))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      3: return CH_SLASH;
      default: return CH_PCT;
    endcase
  endfunction

  task automatic send_expression();
    int operands_left;
    int depth;
    operands_left = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
    depth = 0;
    while (operands_left > 0 || depth > 1) begin
      if (operands_left > 0 && (depth < 2 || $urandom_range(1) == 0)) begin
        send_symbol(rand_operand());
        operands_left--;
        depth++;
      end else begin
        send_symbol(rand_operator());
        depth--;
      end
      if (operands_left == 0 && depth > 1 && $urandom_range(9) == 0) break;
    end
    send_symbol(CH_NUL);
  endtask

  task automatic send_overflow();
    int pushes;
    int pops;
    pushes = $urandom_range(STACK_DEPTH, STACK_DEPTH + 4);
    pops = $urandom_range(3);
    repeat (pushes) send_symbol(rand_operand());
    repeat (pops) send_symbol(rand_operator());
    send_symbol(CH_NUL);
  endtask

  // builds the most negative value as 128^4 * 8, then optionally divides it by -1 or takes the remainder by -1
  task automatic send_most_negative();
    int tail;
    tail = $urandom_range(2);
    send_symbol(8'hB0);
    repeat (3) begin
      send_symbol(8'hB0);
      send_symbol(CH_STAR);
    end
    send_symbol(CH_ZERO + 8'd8);
    send_symbol(CH_STAR);
    if (tail != 0) begin
      send_symbol(CH_ZERO);
      send_symbol(CH_ZERO + 8'd1);
      send_symbol(CH_MINUS);
      send_symbol(tail == 1 ? CH_SLASH : CH_PCT);
    end
    send_symbol(CH_NUL);
  endtask

  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expression terminated");
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.value !== want.value) begin
          $error("value: expected %0d, actual %0d", want.value, res_ch.value);
          failures++;
        end
        if (res_ch.error_code !== want.code) begin
          $error("error_code: expected %0d, actual %0d", want.code, res_ch.error_code);
          failures++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int kind;
    rst = 1'b1;
    sym_ch.valid = 1'b0;
    sym_ch.symbol = '0;
    res_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_symbol(directed_rows[i].symbol, directed_rows[i].typed, directed_rows[i].want);
    end

    while (sent_items < RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        send_expression();
      end else if (kind < 78) begin
        send_overflow();
      end else if (kind < 84) begin
        send_most_negative();
      end else begin
        repeat ($urandom_range(1, 6)) send_symbol(SYM_WIDTH'($urandom_range(255)));
      end
    end
    send_symbol(CH_NUL);
    sym_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/pee_pkg.sv
src/pee_sym_if.sv
src/pee_res_if.sv
src/pee_ram.sv
src/pee_muldiv.sv
src/pee_datapath.sv
src/pee_ctrl.sv
src/postfix_expression_evaluator_core.sv
src/pee_checker.sv
verif/tb_top.sv
